// File: hdl/look_at_view_matrix_assert.svh
// ----------------------------------------------------------------------------
// Look-at view matrix assertion macros
// Shared property wrappers for the look-at view matrix block.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// same-cycle implication
`define LAVM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lavm assertion failed");

// next-cycle implication
`define LAVM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lavm assertion failed");

`endif

// File: hdl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Widths, types and helper functions shared by the look-at view matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package lavm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NW  = 64;                 // normaliser input width
    localparam int MW  = 30;                 // scaled magnitude width
    localparam int SW  = 64;                 // square-root working width
    localparam int SQ  = 32;                 // square-root steps
    localparam int LW  = 31;                 // length width
    localparam int QB  = FRAC_BITS + 2;      // quotient bits
    localparam int UW  = QB + 1;             // signed unit component width
    localparam int RW  = LW + QB;            // divider remainder width
    localparam int PW  = 32 + UW;            // product width
    localparam int DTW = PW + 2;             // dot product width
    localparam int TW  = DTW - FRAC_BITS + 1; // translation before saturation

    typedef logic signed [31:0]   t_q;
    typedef t_q [2:0]             t_qvec;
    typedef logic signed [UW-1:0] t_unit;
    typedef t_unit [2:0]          t_uvec;
    typedef logic signed [NW-1:0] t_wide;
    typedef t_wide [2:0]          t_wvec;

    typedef struct packed {
        t_qvec eye;
        t_qvec up;
        t_uvec d;
        t_uvec r;
        logic  deg;
    } t_side;

    function automatic logic [5:0] f_msb(input logic [NW-1:0] x);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < NW; i++) begin
            if (x[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    function automatic t_q f_sat32(input logic signed [TW-1:0] x);
        logic signed [TW-1:0] maxv;
        logic signed [TW-1:0] minv;
        maxv = TW'(64'sh7FFF_FFFF);
        minv = -maxv - TW'(1);
        if (x > maxv) begin
            return 32'sh7FFF_FFFF;
        end else if (x < minv) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/lavm_norm.sv
// ----------------------------------------------------------------------------
// Look-at view matrix vector normaliser
// Pipelined normalise of a 3-vector: scale, sum of squares, bit-serial square
// root one step per stage, restoring division one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lavm_norm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lavm_pkg::t_wvec  i_vec,
    input  lavm_pkg::t_side  i_side,
    output logic             o_valid,
    output logic             o_zero,
    output lavm_pkg::t_uvec  o_unit,
    output lavm_pkg::t_side  o_side
);
    import lavm_pkg::*;

    // stage 1: magnitudes
    logic          r1_v;
    t_side         r1_side;
    logic [2:0]    r1_neg;
    logic [NW-1:0] r1_mag [3];
    logic [NW-1:0] r1_or;
    logic [NW-1:0] n1_mag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_mag[i] = i_vec[i][NW-1] ? -i_vec[i] : i_vec[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_v    <= i_rst_n & i_valid;
        r1_side <= i_side;
        for (int i = 0; i < 3; i++) begin
            r1_neg[i] <= i_vec[i][NW-1];
            r1_mag[i] <= n1_mag[i];
        end
        r1_or <= n1_mag[0] | n1_mag[1] | n1_mag[2];
    end

    // stage 2: leading one
    logic          r2_v;
    t_side         r2_side;
    logic [2:0]    r2_neg;
    logic [NW-1:0] r2_mag [3];
    logic [5:0]    r2_pos;
    logic          r2_zero;

    always_ff @(posedge i_clk) begin
        r2_v    <= i_rst_n & r1_v;
        r2_side <= r1_side;
        r2_neg  <= r1_neg;
        r2_mag  <= r1_mag;
        r2_pos  <= f_msb(r1_or);
        r2_zero <= (r1_or == '0);
    end

    // stage 3: scale so the largest lies in [2^29, 2^30)
    logic          r3_v;
    t_side         r3_side;
    logic [2:0]    r3_neg;
    logic          r3_zero;
    logic [MW-1:0] r3_m [3];
    logic [NW-1:0] n3_sh [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r2_pos > 6'(MW - 1)) begin
                n3_sh[i] = r2_mag[i] >> (r2_pos - 6'(MW - 1));
            end else begin
                n3_sh[i] = r2_mag[i] << (6'(MW - 1) - r2_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_v    <= i_rst_n & r2_v;
        r3_side <= r2_side;
        r3_neg  <= r2_neg;
        r3_zero <= r2_zero;
        for (int i = 0; i < 3; i++) begin
            r3_m[i] <= n3_sh[i][MW-1:0];
        end
    end

    // stage 4: squares
    logic            r4_v;
    t_side           r4_side;
    logic [2:0]      r4_neg;
    logic            r4_zero;
    logic [MW-1:0]   r4_m [3];
    logic [2*MW-1:0] r4_sq [3];

    always_ff @(posedge i_clk) begin
        r4_v    <= i_rst_n & r3_v;
        r4_side <= r3_side;
        r4_neg  <= r3_neg;
        r4_zero <= r3_zero;
        r4_m    <= r3_m;
        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= (2*MW)'(r3_m[i]) * (2*MW)'(r3_m[i]);
        end
    end

    // square root, entry 0 holds the sum of squares
    logic          r_qv   [SQ+1];
    t_side         r_qside[SQ+1];
    logic [2:0]    r_qneg [SQ+1];
    logic          r_qz   [SQ+1];
    logic [MW-1:0] r_qm   [SQ+1][3];
    logic [SW-1:0] r_s    [SQ+1];
    logic [SW-1:0] r_res  [SQ+1];

    always_ff @(posedge i_clk) begin
        r_qv[0]    <= i_rst_n & r4_v;
        r_qside[0] <= r4_side;
        r_qneg[0]  <= r4_neg;
        r_qz[0]    <= r4_zero;
        r_qm[0]    <= r4_m;
        r_s[0]     <= SW'(r4_sq[0]) + SW'(r4_sq[1]) + SW'(r4_sq[2]);
        r_res[0]   <= '0;
    end

    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * j);
        logic [SW-1:0] w_t;
        assign w_t = r_res[j] + BIT;

        always_ff @(posedge i_clk) begin
            r_qv[j+1]    <= i_rst_n & r_qv[j];
            r_qside[j+1] <= r_qside[j];
            r_qneg[j+1]  <= r_qneg[j];
            r_qz[j+1]    <= r_qz[j];
            r_qm[j+1]    <= r_qm[j];
            if (r_s[j] >= w_t) begin
                r_s[j+1]   <= r_s[j] - w_t;
                r_res[j+1] <= (r_res[j] >> 1) + BIT;
            end else begin
                r_s[j+1]   <= r_s[j];
                r_res[j+1] <= r_res[j] >> 1;
            end
        end
    end

    // division, entry 0 holds the rounded numerators
    logic          r_dv   [QB+1];
    t_side         r_dside[QB+1];
    logic [2:0]    r_dneg [QB+1];
    logic          r_dz   [QB+1];
    logic [LW-1:0] r_dlen [QB+1];
    logic [RW-1:0] r_drem [QB+1][3];
    logic [QB-1:0] r_dq   [QB+1][3];
    logic [LW-1:0] w_len;

    assign w_len = r_res[SQ][LW-1:0];

    always_ff @(posedge i_clk) begin
        r_dv[0]    <= i_rst_n & r_qv[SQ];
        r_dside[0] <= r_qside[SQ];
        r_dneg[0]  <= r_qneg[SQ];
        r_dz[0]    <= r_qz[SQ];
        r_dlen[0]  <= w_len;
        for (int i = 0; i < 3; i++) begin
            r_drem[0][i] <= RW'({r_qm[SQ][i], FRAC_BITS'(0)}) + RW'(w_len >> 1);
            r_dq[0][i]   <= '0;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        logic [RW-1:0] w_dv;
        assign w_dv = RW'(r_dlen[j]) << B;

        always_ff @(posedge i_clk) begin
            r_dv[j+1]    <= i_rst_n & r_dv[j];
            r_dside[j+1] <= r_dside[j];
            r_dneg[j+1]  <= r_dneg[j];
            r_dz[j+1]    <= r_dz[j];
            r_dlen[j+1]  <= r_dlen[j];
            for (int i = 0; i < 3; i++) begin
                if (r_drem[j][i] >= w_dv) begin
                    r_drem[j+1][i] <= r_drem[j][i] - w_dv;
                    r_dq[j+1][i]   <= r_dq[j][i] | (QB'(1) << B);
                end else begin
                    r_drem[j+1][i] <= r_drem[j][i];
                    r_dq[j+1][i]   <= r_dq[j][i];
                end
            end
        end
    end

    // sign
    always_ff @(posedge i_clk) begin
        o_valid <= i_rst_n & r_dv[QB];
        o_zero  <= r_dz[QB];
        o_side  <= r_dside[QB];
        for (int i = 0; i < 3; i++) begin
            o_unit[i] <= r_dneg[QB][i] ? -$signed({1'b0, r_dq[QB][i]})
                                       : $signed({1'b0, r_dq[QB][i]});
        end
    end

endmodule

`default_nettype wire

// File: hdl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds the four rows of a look-at view matrix from eye, target and up.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the nine Q16.16 camera fields and raise start; the item is taken at
//   a rising edge with start high and busy low. busy then stays high while the
//   gap counter runs down, and no new item is taken while busy is high.
//   Each item yields four rows, row_index 0 to 3, back to back and marked by
//   o_valid; o_last_row flags row 3. o_degenerate is set on all four
//   rows when a vector had zero length, and the entries are then zero.
//   Row 0 comes out of three normalisers in series, each with a 32-step
//   square root and a FRAC_BITS+2 step divider, one step per stage.
//   The receiver cannot stall; rows are shown for one cycle only.
//   Reset (synchronous, active low) clears all valid bits and the busy
//   counter; items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "look_at_view_matrix_assert.svh"

module look_at_view_matrix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_eye_x,
    input  logic [31:0] i_eye_y,
    input  logic [31:0] i_eye_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_up_x,
    input  logic [31:0] i_up_y,
    input  logic [31:0] i_up_z,
    output logic        busy,
    output logic        o_valid,
    output logic [1:0]  o_row_index,
    output logic [31:0] o_entry_0,
    output logic [31:0] o_entry_1,
    output logic [31:0] o_entry_2,
    output logic [31:0] o_entry_3,
    output logic        o_degenerate,
    output logic        o_last_row
);
    import lavm_pkg::*;

    logic [1:0] r_gap;
    logic       w_acc;

    assign busy  = (r_gap != 2'd0);
    assign w_acc = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
        end else if (w_acc) begin
            r_gap <= 2'd3;
        end else if (busy) begin
            r_gap <= r_gap - 2'd1;
        end
    end

    // capture
    logic  r0_v;
    t_qvec r0_eye, r0_tgt, r0_up;

    always_ff @(posedge i_clk) begin
        r0_v   <= i_rst_n & w_acc;
        r0_eye <= {i_eye_z, i_eye_y, i_eye_x};
        r0_tgt <= {i_target_z, i_target_y, i_target_x};
        r0_up  <= {i_up_z, i_up_y, i_up_x};
    end

    // forward direction
    logic  r1_v;
    t_wvec r1_t;
    t_side r1_side;

    always_ff @(posedge i_clk) begin
        r1_v <= i_rst_n & r0_v;
        for (int i = 0; i < 3; i++) begin
            r1_t[i] <= NW'(r0_tgt[i]) - NW'(r0_eye[i]);
        end
        r1_side.eye <= r0_eye;
        r1_side.up  <= r0_up;
        r1_side.d   <= '0;
        r1_side.r   <= '0;
        r1_side.deg <= 1'b0;
    end

    logic  n1_v, n1_z;
    t_uvec n1_u;
    t_side n1_s;

    lavm_norm u_norm_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .i_vec   (r1_t),
        .i_side  (r1_side),
        .o_valid (n1_v),
        .o_zero  (n1_z),
        .o_unit  (n1_u),
        .o_side  (n1_s)
    );

    // up x D
    logic                 r2_v;
    t_side                r2_side;
    t_side                n_side2;
    logic signed [PW-1:0] r2_pa [3];
    logic signed [PW-1:0] r2_pb [3];

    always_comb begin
        n_side2     = n1_s;
        n_side2.d   = n1_u;
        n_side2.deg = n1_z;
    end

    always_ff @(posedge i_clk) begin
        r2_v     <= i_rst_n & n1_v;
        r2_side  <= n_side2;
        r2_pa[0] <= PW'(n1_s.up[1]) * PW'(n1_u[2]);
        r2_pb[0] <= PW'(n1_s.up[2]) * PW'(n1_u[1]);
        r2_pa[1] <= PW'(n1_s.up[2]) * PW'(n1_u[0]);
        r2_pb[1] <= PW'(n1_s.up[0]) * PW'(n1_u[2]);
        r2_pa[2] <= PW'(n1_s.up[0]) * PW'(n1_u[1]);
        r2_pb[2] <= PW'(n1_s.up[1]) * PW'(n1_u[0]);
    end

    logic  r3_v;
    t_wvec r3_t;
    t_side r3_side;

    always_ff @(posedge i_clk) begin
        r3_v    <= i_rst_n & r2_v;
        r3_side <= r2_side;
        for (int i = 0; i < 3; i++) begin
            r3_t[i] <= NW'(r2_pa[i] - r2_pb[i]);
        end
    end

    logic  n2_v, n2_z;
    t_uvec n2_u;
    t_side n2_s;

    lavm_norm u_norm_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_vec   (r3_t),
        .i_side  (r3_side),
        .o_valid (n2_v),
        .o_zero  (n2_z),
        .o_unit  (n2_u),
        .o_side  (n2_s)
    );

    // D x R
    logic                 r4_v;
    t_side                r4_side;
    t_side                n_side4;
    logic signed [PW-1:0] r4_pa [3];
    logic signed [PW-1:0] r4_pb [3];

    always_comb begin
        n_side4     = n2_s;
        n_side4.r   = n2_u;
        n_side4.deg = n2_s.deg | n2_z;
    end

    always_ff @(posedge i_clk) begin
        r4_v     <= i_rst_n & n2_v;
        r4_side  <= n_side4;
        r4_pa[0] <= PW'(n2_s.d[1]) * PW'(n2_u[2]);
        r4_pb[0] <= PW'(n2_s.d[2]) * PW'(n2_u[1]);
        r4_pa[1] <= PW'(n2_s.d[2]) * PW'(n2_u[0]);
        r4_pb[1] <= PW'(n2_s.d[0]) * PW'(n2_u[2]);
        r4_pa[2] <= PW'(n2_s.d[0]) * PW'(n2_u[1]);
        r4_pb[2] <= PW'(n2_s.d[1]) * PW'(n2_u[0]);
    end

    logic  r5_v;
    t_wvec r5_t;
    t_side r5_side;

    always_ff @(posedge i_clk) begin
        r5_v    <= i_rst_n & r4_v;
        r5_side <= r4_side;
        for (int i = 0; i < 3; i++) begin
            r5_t[i] <= NW'(r4_pa[i] - r4_pb[i]);
        end
    end

    logic  n3_v, n3_z;
    t_uvec n3_u;
    t_side n3_s;

    lavm_norm u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_vec   (r5_t),
        .i_side  (r5_side),
        .o_valid (n3_v),
        .o_zero  (n3_z),
        .o_unit  (n3_u),
        .o_side  (n3_s)
    );

    // translation: products
    t_uvec                w_ax [3];
    logic                 r6_v, r6_deg;
    t_uvec                r6_ax [3];
    logic signed [PW-1:0] r6_p [3][3];

    assign w_ax[0] = n3_s.r;
    assign w_ax[1] = n3_u;
    assign w_ax[2] = n3_s.d;

    always_ff @(posedge i_clk) begin
        r6_v   <= i_rst_n & n3_v;
        r6_deg <= n3_s.deg | n3_z;
        r6_ax  <= w_ax;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                r6_p[k][i] <= PW'(w_ax[k][i]) * PW'(n3_s.eye[i]);
            end
        end
    end

    // translation: sums
    logic                  r7_v, r7_deg;
    t_uvec                 r7_ax [3];
    logic signed [DTW-1:0] r7_dot [3];

    always_ff @(posedge i_clk) begin
        r7_v   <= i_rst_n & r6_v;
        r7_deg <= r6_deg;
        r7_ax  <= r6_ax;
        for (int k = 0; k < 3; k++) begin
            r7_dot[k] <= DTW'(r6_p[k][0]) + DTW'(r6_p[k][1]) + DTW'(r6_p[k][2]);
        end
    end

    // round, negate, saturate into the row hold
    logic signed [DTW-1:0] w_y  [3];
    logic signed [TW-1:0]  w_tr [3];
    logic [31:0]           r_hold [4][4];
    logic                  r_deg, r_act;
    logic [1:0]            r_cnt;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_y[k]  = r7_dot[k] + (DTW'(1) <<< (FRAC_BITS - 1));
            w_tr[k] = -TW'(w_y[k] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r7_v) begin
            r_deg <= r7_deg;
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_hold[k][i] <= r7_deg ? 32'd0 : 32'(r7_ax[k][i]);
                end
                r_hold[k][3] <= r7_deg ? 32'd0 : f_sat32(w_tr[k]);
            end
            r_hold[3][0] <= 32'd0;
            r_hold[3][1] <= 32'd0;
            r_hold[3][2] <= 32'd0;
            r_hold[3][3] <= r7_deg ? 32'd0 : (32'd1 << FRAC_BITS);
        end
    end

    // row sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_cnt   <= 2'd0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_act;
            if (r7_v) begin
                r_act <= 1'b1;
                r_cnt <= 2'd0;
            end else if (r_act) begin
                r_act <= (r_cnt != 2'd3);
                r_cnt <= r_cnt + 2'd1;
            end
        end
        o_row_index  <= r_cnt;
        o_last_row   <= (r_cnt == 2'd3);
        o_degenerate <= r_deg;
        o_entry_0    <= r_hold[r_cnt][0];
        o_entry_1    <= r_hold[r_cnt][1];
        o_entry_2    <= r_hold[r_cnt][2];
        o_entry_3    <= r_hold[r_cnt][3];
    end

    `LAVM_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, w_acc, busy)
    `LAVM_ASSERT_NEXT(a_rows_back_to_back, i_clk, i_rst_n, o_valid && !o_last_row,
                      o_valid && o_row_index == $past(o_row_index) + 2'd1)
    `LAVM_ASSERT_NEXT(a_deg_held, i_clk, i_rst_n, o_valid && o_degenerate && !o_last_row, o_degenerate)
    `LAVM_ASSERT_IMPL(a_deg_zero, i_clk, i_rst_n, o_valid && o_degenerate, o_entry_0 == 32'd0 && o_entry_3 == 32'd0)

endmodule

`default_nettype wire

// File: bench/look_at_view_matrix_tb.sv
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Drives camera items through the block and compares every matrix row against
// an integer predictor of the normalise, cross product and translation steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix_tb;

    localparam int FB      = lavm_pkg::FRAC_BITS;
    localparam int LAT     = 3 * FB + 140;
    localparam int LIMIT   = 2000000;

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] e0;
        logic [31:0] e1;
        logic [31:0] e2;
        logic [31:0] e3;
        logic        deg;
        logic        last;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
    logic [31:0] tgt_x = '0, tgt_y = '0, tgt_z = '0;
    logic [31:0] up_x = '0, up_y = '0, up_z = '0;
    logic        busy;
    logic        o_valid;
    logic [1:0]  o_row_index;
    logic [31:0] o_entry_0, o_entry_1, o_entry_2, o_entry_3;
    logic        o_degenerate, o_last_row;

    t_row        rows_due[$];
    int          n_err = 0;
    int          n_rows = 0;
    int          n_items = 0;
    int          n_deg = 0;
    longint      cycles = 0;
    bit          idle_on = 1'b1;

    look_at_view_matrix i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start),
        .i_eye_x(eye_x), .i_eye_y(eye_y), .i_eye_z(eye_z),
        .i_target_x(tgt_x), .i_target_y(tgt_y), .i_target_z(tgt_z),
        .i_up_x(up_x), .i_up_y(up_y), .i_up_z(up_z),
        .busy(busy), .o_valid(o_valid), .o_row_index(o_row_index),
        .o_entry_0(o_entry_0), .o_entry_1(o_entry_1), .o_entry_2(o_entry_2),
        .o_entry_3(o_entry_3), .o_degenerate(o_degenerate), .o_last_row(o_last_row)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---- predictor ----
    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit unit_vec(input longint v[3], output longint u[3]);
        logic [63:0] m[3];
        logic [63:0] mx, s, len, q;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return 1'b0;
        end
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic [31:0] translation(input longint dot);
        longint y, t;
        y = dot + (longint'(1) << (FB - 1));
        t = -(y >>> FB);
        if (t > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (t < -64'sh8000_0000) return 32'h8000_0000;
        return t[31:0];
    endfunction

    task automatic predict_view_rows(input logic [31:0] f[9]);
        longint eye[3], d[3], r[3], u[3], t[3], up[3], ent[4][4], dot;
        bit ok;
        t_row rw;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'($signed(f[i]));
            t[i] = longint'($signed(f[3 + i])) - eye[i];
            up[i] = longint'($signed(f[6 + i]));
        end
        ok = unit_vec(t, d);
        if (ok) begin
            cross3(up, d, t);
            ok = unit_vec(t, r);
        end
        if (ok) begin
            cross3(d, r, t);
            ok = unit_vec(t, u);
        end
        for (int k = 0; k < 4; k++)
            for (int i = 0; i < 4; i++) ent[k][i] = 0;
        if (ok) begin
            for (int i = 0; i < 3; i++) begin
                ent[0][i] = r[i];
                ent[1][i] = u[i];
                ent[2][i] = d[i];
            end
            for (int k = 0; k < 3; k++) begin
                dot = 0;
                for (int i = 0; i < 3; i++) dot += ent[k][i] * eye[i];
                ent[k][3] = longint'($signed(translation(dot)));
            end
            ent[3][3] = longint'(1) << FB;
        end else begin
            n_deg++;
        end
        for (int k = 0; k < 4; k++) begin
            rw.row  = k[1:0];
            rw.e0   = ent[k][0][31:0];
            rw.e1   = ent[k][1][31:0];
            rw.e2   = ent[k][2][31:0];
            rw.e3   = ent[k][3][31:0];
            rw.deg  = !ok;
            rw.last = (k == 3);
            rows_due.push_back(rw);
        end
    endtask

    // ---- row checker ----
    always @(posedge i_clk) begin
        t_row ex;
        if (i_rst_n && o_valid) begin
            n_rows++;
            if (rows_due.size() == 0) begin
                $error("unexpected row %0d", o_row_index);
                n_err++;
            end else begin
                ex = rows_due.pop_front();
                if (o_row_index !== ex.row) begin
                    $error("row_index exp %0d got %0d", ex.row, o_row_index); n_err++;
                end
                if (o_entry_0 !== ex.e0) begin
                    $error("entry_0 exp %h got %h", ex.e0, o_entry_0); n_err++;
                end
                if (o_entry_1 !== ex.e1) begin
                    $error("entry_1 exp %h got %h", ex.e1, o_entry_1); n_err++;
                end
                if (o_entry_2 !== ex.e2) begin
                    $error("entry_2 exp %h got %h", ex.e2, o_entry_2); n_err++;
                end
                if (o_entry_3 !== ex.e3) begin
                    $error("entry_3 exp %h got %h", ex.e3, o_entry_3); n_err++;
                end
                if (o_degenerate !== ex.deg) begin
                    $error("degenerate exp %0d got %0d", ex.deg, o_degenerate); n_err++;
                end
                if (o_last_row !== ex.last) begin
                    $error("last_row exp %0d got %0d", ex.last, o_last_row); n_err++;
                end
            end
        end
    end

    // ---- item driver ----
    task automatic send_camera(input logic [31:0] f[9]);
        while (idle_on && $urandom_range(99) < 9) @(negedge i_clk);
        {eye_x, eye_y, eye_z} = {f[0], f[1], f[2]};
        {tgt_x, tgt_y, tgt_z} = {f[3], f[4], f[5]};
        {up_x, up_y, up_z}    = {f[6], f[7], f[8]};
        start = 1'b1;
        // busy is stable from the falling edge up to the next rising edge
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_view_rows(f);
        n_items++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic logic [31:0] rand_q(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] f[9];
        // plain camera at (0,0,5) looking at origin, y up
        f = '{0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0};
        send_camera(f);
        // target equals eye
        f = '{1 << 16, 2 << 16, 3 << 16, 1 << 16, 2 << 16, 3 << 16, 0, 1 << 16, 0};
        send_camera(f);
        // up parallel to forward
        f = '{0, 0, 0, 0, 3 << 16, 0, 0, 1 << 16, 0};
        send_camera(f);
        // zero up
        f = '{0, 0, 0, 1 << 16, 0, 0, 0, 0, 0};
        send_camera(f);
        // extremes: eye and target at opposite limits, translation saturates
        f = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
        send_camera(f);
        f = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        send_camera(f);
        // tiny differences, scaling up
        f = '{0, 0, 0, 1, 0, 0, 0, 0, 1};
        send_camera(f);
        f = '{32'hFFFF_FFFF, 0, 0, 0, 1, 32'hFFFF_FFFF, 1, 1, 1};
        send_camera(f);
        for (int n = 0; n < 8; n++) begin
            for (int i = 0; i < 9; i++) f[i] = rand_q(2);
            send_camera(f);
        end
    endtask

    task automatic test_random(input int count);
        logic [31:0] f[9];
        int mode;
        for (int n = 0; n < count; n++) begin
            idle_on = !(n >= count / 3 && n < count / 2);
            mode = $urandom_range(3);
            for (int i = 0; i < 9; i++) f[i] = rand_q(mode);
            if ($urandom_range(19) == 0) begin
                f[3] = f[0]; f[4] = f[1]; f[5] = f[2];
            end
            send_camera(f);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(364);
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
        $display("Sent %0d camera items (%0d degenerate), checked %0d matrix rows.",
                 n_items, n_deg, n_rows);
        if (n_err == 0 && rows_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/lavm_pkg.sv
hdl/lavm_norm.sv
hdl/look_at_view_matrix.sv
bench/look_at_view_matrix_tb.sv
